FILE: design/wtpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wtpm_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int WORD_BITS_DEF   = 32;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int REQ_TYPE_W = 2;
  localparam int PAT_IDX_W  = 4;
  localparam int PAT_IDX_N  = 1 << PAT_IDX_W;
  localparam int CFG_LEN_W  = 5;
  localparam int OUT_BITS   = 16;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_TEXT = 2'd1,
    REQ_EOL  = 2'd2
  } req_e;

  typedef struct packed {
    logic ok;
    logic fixed;
  } cell_stat_t;

endpackage
`default_nettype wire

FILE: design/wtpm_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface wtpm_req_if
  import wtpm_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [PAT_IDX_W-1:0]  pattern_index;
  logic [WORD_BITS-1:0]  token_value;
  logic                  token_wild;

  modport source (
    output valid, req_type, pattern_index, token_value, token_wild,
    input  ready
  );
  modport sink (
    input  valid, req_type, pattern_index, token_value, token_wild,
    output ready
  );
endinterface

interface wtpm_match_if
  import wtpm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] match_line;
  logic [OUT_BITS-1:0] match_word;

  modport source (
    output valid, match_line, match_word,
    input  ready
  );
  modport sink (
    input  valid, match_line, match_word,
    output ready
  );
endinterface
`default_nettype wire

FILE: design/wtpm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module wtpm_cell
  import wtpm_pkg::*;
#(
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    shift_i,
  input  wire logic [WORD_BITS-1:0]    word_i,
  input  wire logic [2*COUNT_BITS-1:0] place_i,
  input  wire logic [WORD_BITS-1:0]    pat_value_i,
  input  wire logic                    pat_wild_i,
  input  wire logic                    active_i,
  output logic      [WORD_BITS-1:0]    word_o,
  output logic      [2*COUNT_BITS-1:0] place_o,
  output cell_stat_t                   stat_o
);

  logic [WORD_BITS-1:0]    word_q;
  logic [2*COUNT_BITS-1:0] place_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q  <= '0;
      place_q <= '0;
    end else if (shift_i) begin
      word_q  <= word_i;
      place_q <= place_i;
    end
  end

  always_comb begin
    stat_o.ok    = !active_i || pat_wild_i || (pat_value_i == word_q);
    stat_o.fixed = active_i && !pat_wild_i;
  end

  assign word_o  = word_q;
  assign place_o = place_q;

endmodule
`default_nettype wire

FILE: design/wtpm_pattern.sv
`timescale 1ns / 1ps
`default_nettype none
module wtpm_pattern
  import wtpm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int LEN_W       = $clog2(MAX_PATTERN_DEF + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [PAT_IDX_W-1:0] idx_i,
  input  wire logic [WORD_BITS-1:0] value_i,
  input  wire logic                 wild_i,
  input  wire logic [LEN_W-1:0]     len_i,
  output logic      [WORD_BITS-1:0] val_o  [MAX_PATTERN],
  output logic                      wild_o [MAX_PATTERN]
);

  localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [WORD_BITS-1:0] row_val_q  [MAX_PATTERN];
  logic                 row_wild_q [MAX_PATTERN];
  logic [PW-1:0]        slot;
  logic [PW-1:0]        row;
  logic [LEN_W-1:0]     shamt;
  logic [WORD_BITS-1:0] st_val  [LEN_W+1][MAX_PATTERN];
  logic                 st_wild [LEN_W+1][MAX_PATTERN];

  always_comb begin
    slot = '0;
    for (int v = 0; v < PAT_IDX_N; v++) begin
      if (idx_i == PAT_IDX_W'(v)) begin
        slot = PW'(v % MAX_PATTERN);
      end
    end
    row = PW'(MAX_PATTERN - 1) - slot;
  end

  // rows hold the pattern back to front
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      row_val_q[row]  <= value_i;
      row_wild_q[row] <= wild_i;
    end
  end

  // align pattern word len-1-i onto cell i
  always_comb begin
    shamt = LEN_W'(MAX_PATTERN) - len_i;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      st_val[0][i]  = row_val_q[i];
      st_wild[0][i] = row_wild_q[i];
    end
    for (int b = 0; b < LEN_W; b++) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (!shamt[b]) begin
          st_val[b+1][i]  = st_val[b][i];
          st_wild[b+1][i] = st_wild[b][i];
        end else if (i + (1 << b) < MAX_PATTERN) begin
          st_val[b+1][i]  = st_val[b][i + (1 << b)];
          st_wild[b+1][i] = st_wild[b][i + (1 << b)];
        end else begin
          st_val[b+1][i]  = '0;
          st_wild[b+1][i] = 1'b0;
        end
      end
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      val_o[i]  = st_val[LEN_W][i];
      wild_o[i] = st_wild[LEN_W][i];
    end
  end

endmodule
`default_nettype wire

FILE: design/wildcard_token_pattern_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Wildcard token pattern matcher. Load pattern words by index, set the pattern
// length through the configuration port while idle, then stream text words and
// end-of-line items; every completed match of a pattern with a non-wildcard
// word yields one item with the line and word number of its first word. The
// block takes one item per cycle: a text word shifts a row of window cells at
// its accept edge, all cells compare against the aligned pattern, and a hit
// lands in the output register once that register is free. Input ready drops
// only while a comparison waits for the output register to be taken.
module wildcard_token_pattern_matcher
  import wtpm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_LEN_W-1:0] cfg_wdata_i,
  wtpm_req_if.sink                  req_i,
  wtpm_match_if.source              match_o
);

  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int PLACE_W = 2 * COUNT_BITS;

  logic [CFG_LEN_W-1:0]  cfg_len_q;
  logic [LEN_W-1:0]      len_eff;
  logic [LEN_W-1:0]      seen_q, seen_d;
  logic [COUNT_BITS-1:0] line_q, line_d;
  logic [COUNT_BITS-1:0] word_q, word_d;
  logic [COUNT_BITS-1:0] word_inc;
  logic                  eval_q, eval_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]   out_line_q, out_word_q;
  logic                  out_free;
  logic                  eval_go;
  logic                  req_fire;
  logic                  text_fire;
  logic                  load_fire;
  logic                  eol_fire;
  logic                  hit;
  logic [PLACE_W-1:0]    first_place;

  logic [WORD_BITS-1:0]   win_word  [MAX_PATTERN];
  logic [PLACE_W-1:0]     win_place [MAX_PATTERN];
  logic [WORD_BITS-1:0]   pat_val   [MAX_PATTERN];
  logic                   pat_wild  [MAX_PATTERN];
  cell_stat_t             stat      [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_ok, cell_fixed, cell_active, cell_last;

  assign out_free    = !out_valid_q || match_o.ready;
  assign eval_go     = eval_q && out_free;
  assign req_i.ready = !eval_q || out_free;
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    text_fire = 1'b0;
    load_fire = 1'b0;
    eol_fire  = 1'b0;
    case (req_i.req_type)
      REQ_LOAD: load_fire = req_fire;
      REQ_TEXT: text_fire = req_fire;
      REQ_EOL:  eol_fire  = req_fire;
      default:  ;
    endcase
  end

  always_comb begin
    if (32'(cfg_len_q) > 32'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(cfg_len_q);
    end
  end

  always_comb begin
    word_inc = (word_q == '1) ? word_q : word_q + COUNT_BITS'(1);
    line_d   = line_q;
    word_d   = word_q;
    seen_d   = seen_q;
    if (text_fire) begin
      word_d = word_inc;
      if (seen_q != LEN_W'(MAX_PATTERN)) begin
        seen_d = seen_q + LEN_W'(1);
      end
    end else if (eol_fire) begin
      word_d = '0;
      line_d = (line_q == '1) ? line_q : line_q + COUNT_BITS'(1);
    end
  end

  wtpm_pattern #(
    .MAX_PATTERN (MAX_PATTERN),
    .WORD_BITS   (WORD_BITS),
    .LEN_W       (LEN_W)
  ) u_pattern (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .idx_i   (req_i.pattern_index),
    .value_i (req_i.token_value),
    .wild_i  (req_i.token_wild),
    .len_i   (len_eff),
    .val_o   (pat_val),
    .wild_o  (pat_wild)
  );

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cell_active[i] = LEN_W'(i) < len_eff;
      cell_last[i]   = LEN_W'(i + 1) == len_eff;
      cell_ok[i]     = stat[i].ok;
      cell_fixed[i]  = stat[i].fixed;
    end
  end

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    logic [WORD_BITS-1:0] word_in;
    logic [PLACE_W-1:0]   place_in;

    if (g == 0) begin : g_head
      assign word_in  = req_i.token_value;
      assign place_in = {line_q, word_inc};
    end else begin : g_body
      assign word_in  = win_word[g-1];
      assign place_in = win_place[g-1];
    end

    wtpm_cell #(
      .WORD_BITS  (WORD_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (text_fire),
      .word_i      (word_in),
      .place_i     (place_in),
      .pat_value_i (pat_val[g]),
      .pat_wild_i  (pat_wild[g]),
      .active_i    (cell_active[g]),
      .word_o      (win_word[g]),
      .place_o     (win_place[g]),
      .stat_o      (stat[g])
    );
  end

  always_comb begin
    first_place = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (cell_last[i]) begin
        first_place = first_place | win_place[i];
      end
    end
    hit = (len_eff != '0) && (seen_q >= len_eff) && (&cell_ok) && (|cell_fixed);
  end

  always_comb begin
    eval_d = eval_q;
    if (eval_go) begin
      eval_d = 1'b0;
    end
    if (text_fire) begin
      eval_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (eval_go && hit) begin
      out_valid_d = 1'b1;
    end else if (match_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q   <= CFG_LEN_W'(1);
      seen_q      <= '0;
      line_q      <= COUNT_BITS'(1);
      word_q      <= '0;
      eval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_len_q <= cfg_wdata_i;
      end
      seen_q      <= seen_d;
      line_q      <= line_d;
      word_q      <= word_d;
      eval_q      <= eval_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go && hit) begin
      out_line_q <= OUT_BITS'(first_place[PLACE_W-1:COUNT_BITS]);
      out_word_q <= OUT_BITS'(first_place[COUNT_BITS-1:0]);
    end
  end

  assign match_o.valid      = out_valid_q;
  assign match_o.match_line = out_line_q;
  assign match_o.match_word = out_word_q;

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import wtpm_pkg::*;

  localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [OUT_BITS-1:0] COUNT_TOP = '1;
  localparam int DEPTH = MAX_PATTERN_DEF;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic [REQ_TYPE_W-1:0]    kind;
    logic [PAT_IDX_W-1:0]     idx;
    logic [WORD_BITS_DEF-1:0] val;
    logic                     wild;
  } req_item_t;

  typedef struct {
    logic [OUT_BITS-1:0] line;
    logic [OUT_BITS-1:0] word;
  } place_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_LEN_W-1:0] cfg_wdata_i;

  wtpm_req_if   req_if ();
  wtpm_match_if match_if ();

  wildcard_token_pattern_matcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if.sink),
    .match_o     (match_if.source)
  );

  logic [WORD_BITS_DEF-1:0] pat_val   [DEPTH];
  logic                     pat_wild  [DEPTH];
  logic [WORD_BITS_DEF-1:0] win_val   [DEPTH];
  place_t                   win_place [DEPTH];
  int                       words_held;
  logic [OUT_BITS-1:0]      cur_line;
  logic [OUT_BITS-1:0]      cur_word;
  logic [CFG_LEN_W-1:0]     pat_len;

  place_t pending_matches[$];
  int     fails;
  bit     src_idle_en;
  bit     sink_idle_en;
  int     hold_request;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic advance_matcher(input req_item_t it);
    int n;
    int k;
    bit hit;
    bit any_fixed;
    case (it.kind)
      REQ_LOAD: begin
        pat_val[it.idx]  = it.val;
        pat_wild[it.idx] = it.wild;
      end
      REQ_EOL: begin
        if (cur_line != COUNT_TOP) cur_line++;
        cur_word = '0;
      end
      REQ_TEXT: begin
        if (cur_word != COUNT_TOP) cur_word++;
        for (k = DEPTH - 1; k > 0; k--) begin
          win_val[k]   = win_val[k-1];
          win_place[k] = win_place[k-1];
        end
        win_val[0]        = it.val;
        win_place[0].line = cur_line;
        win_place[0].word = cur_word;
        if (words_held < DEPTH) words_held++;
        n = (pat_len > DEPTH) ? DEPTH : int'(pat_len);
        if (n != 0 && words_held >= n) begin
          hit = 1'b1;
          any_fixed = 1'b0;
          for (k = 0; k < n; k++) begin
            if (!pat_wild[k]) begin
              any_fixed = 1'b1;
              if (pat_val[k] != win_val[n-1-k]) hit = 1'b0;
            end
          end
          if (hit && any_fixed) pending_matches.insert(pending_matches.size(), win_place[n-1]);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input req_item_t it);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= it.kind;
    req_if.pattern_index <= it.idx;
    req_if.token_value   <= it.val;
    req_if.token_wild    <= it.wild;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    advance_matcher(it);
  endtask

  task automatic send_req(input logic [REQ_TYPE_W-1:0] kind, input logic [PAT_IDX_W-1:0] idx,
                          input logic [WORD_BITS_DEF-1:0] val, input logic wild);
    req_item_t it;
    it.kind = kind;
    it.idx  = idx;
    it.val  = val;
    it.wild = wild;
    send_item(it);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_length(input int len);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_LEN_W'(len);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pat_len = CFG_LEN_W'(len);
  endtask

  task automatic test_directed();
    int k;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    set_length(3);
    send_req(REQ_LOAD, PAT_IDX_W'(0), '1, 1'b0);
    send_req(REQ_LOAD, PAT_IDX_W'(1), '0, 1'b1);
    send_req(REQ_LOAD, PAT_IDX_W'(2), '0, 1'b0);
    for (k = 3; k < DEPTH; k++) send_req(REQ_LOAD, PAT_IDX_W'(k), $urandom, k[0]);
    send_req(REQ_TEXT, PAT_IDX_W'($urandom), '1, 1'b0);
    send_req(REQ_TEXT, PAT_IDX_W'($urandom), 32'h1234_5678, 1'b1);
    send_req(REQ_EOL, PAT_IDX_W'($urandom), $urandom, 1'b0);
    send_req(REQ_UNKNOWN, '1, '1, 1'b1);
    send_req(REQ_TEXT, PAT_IDX_W'($urandom), '0, 1'b0);
    send_req(REQ_TEXT, PAT_IDX_W'($urandom), '1, 1'b0);
    send_req(REQ_TEXT, PAT_IDX_W'($urandom), 32'h5555_5555, 1'b0);
    send_req(REQ_TEXT, PAT_IDX_W'($urandom), '0, 1'b0);
    set_length(0);
    send_req(REQ_TEXT, PAT_IDX_W'($urandom), '0, 1'b0);
    set_length(31);
    send_req(REQ_TEXT, PAT_IDX_W'($urandom), '1, 1'b0);
    set_length(16);
    send_req(REQ_TEXT, PAT_IDX_W'($urandom), '0, 1'b0);
    set_length(1);
    send_req(REQ_LOAD, PAT_IDX_W'(0), '1, 1'b1);
    send_req(REQ_TEXT, PAT_IDX_W'($urandom), '1, 1'b0);
  endtask

  task automatic test_random();
    int phase;
    int made;
    int n;
    int k;
    int r;
    bit all_wild;
    int len;
    for (phase = 0; phase < 22; phase++) begin
      r = $urandom_range(0, 9);
      if (phase == 0) len = 1;
      else if (phase == 21) len = 16;
      else if (r == 0) len = 0;
      else if (r == 1) len = 16;
      else if (r == 2) len = $urandom_range(17, 31);
      else if (r < 5) len = $urandom_range(5, 15);
      else len = $urandom_range(1, 4);
      set_length(len);
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      all_wild = ($urandom_range(0, 9) == 0);
      for (k = 0; k < DEPTH; k++)
        send_req(REQ_LOAD, PAT_IDX_W'(k), $urandom_range(0, 3),
                 all_wild || ($urandom_range(0, 3) == 0));
      made = 0;
      while (made < 64) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          n = (len == 0) ? 3 : ((len > DEPTH) ? DEPTH : len);
          for (k = 0; k < n; k++) begin
            if (k > 0 && $urandom_range(0, 9) == 0)
              send_req(REQ_EOL, PAT_IDX_W'($urandom), $urandom, 1'b0);
            send_req(REQ_TEXT, PAT_IDX_W'($urandom),
                     pat_wild[k] ? $urandom_range(0, 3) : pat_val[k], 1'($urandom));
          end
          made += n;
        end else if (r < 25) begin
          send_req(REQ_EOL, PAT_IDX_W'($urandom), $urandom, 1'($urandom));
          made++;
        end else if (r < 28) begin
          send_req(REQ_LOAD, PAT_IDX_W'($urandom),
                   $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3),
                   $urandom_range(0, 3) == 0);
          made++;
        end else if (r < 30) begin
          send_req(REQ_UNKNOWN, PAT_IDX_W'($urandom), $urandom, 1'($urandom));
        end else if (r < 36) begin
          send_req(REQ_TEXT, PAT_IDX_W'($urandom), $urandom, 1'($urandom));
          made++;
        end else begin
          send_req(REQ_TEXT, PAT_IDX_W'($urandom), $urandom_range(0, 3), 1'($urandom));
          made++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    int k;
    set_length(1);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b1;
    send_req(REQ_LOAD, PAT_IDX_W'(0), 9, 1'b0);
    hold_request = 300;
    for (k = 0; k < 120; k++) send_req(REQ_TEXT, PAT_IDX_W'($urandom), 9, 1'($urandom));
    wait_idle();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_LOAD;
    req_if.pattern_index = '0;
    req_if.token_value   = '0;
    req_if.token_wild    = 1'b0;
    match_if.ready       = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      pat_val[k]   = '0;
      pat_wild[k]  = 1'b0;
      win_val[k]   = '0;
      win_place[k] = '{line: '0, word: '0};
    end
    words_held   = 0;
    cur_line     = OUT_BITS'(1);
    cur_word     = '0;
    pat_len      = CFG_LEN_W'(1);
    fails        = 0;
    hold_request = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    wait_idle();
    if (fails == 0) begin
      $display("[wildcard_token_pattern_matcher] OK");
    end else begin
      $display("[wildcard_token_pattern_matcher] ERROR");
    end
    $finish;
  end

  initial begin : sink_driver
    logic rdy;
    int span;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request > 0) begin
        rdy = 1'b0;
        span = hold_request;
        hold_request = 0;
      end else if (!sink_idle_en) begin
        rdy = 1'b1;
        span = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        rdy = 1'b0;
        span = pick_gap() + 1;
      end else begin
        rdy = 1'b1;
        span = $urandom_range(1, 10);
      end
      match_if.ready <= rdy;
      repeat (span) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    place_t want;
    if (rst_ni && match_if.valid === 1'b1 && match_if.ready === 1'b1) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected match, expected none, actual line %0d word %0d", $time,
                 match_if.match_line, match_if.match_word);
        fails++;
      end else begin
        want = pending_matches.pop_front();
        if (match_if.match_line !== want.line) begin
          $display("%0t: match_line expected %0d actual %0d", $time, want.line,
                   match_if.match_line);
          fails++;
        end
        if (match_if.match_word !== want.word) begin
          $display("%0t: match_word expected %0d actual %0d", $time, want.word,
                   match_if.match_word);
          fails++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("[wildcard_token_pattern_matcher] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
design/wtpm_pkg.sv
design/wtpm_if.sv
design/wtpm_cell.sv
design/wtpm_pattern.sv
design/wildcard_token_pattern_matcher.sv
test/tb.sv
